// ----- rtl/css_pkg.sv -----
// Package for the comment stripper with symbol padding.
// Holds payload structs, scan modes, queue command format and character codes.
// No dependencies.
package css_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic [1:0]             status;
    logic                   last_of_run;
    logic [LINE_BITS-1:0]   error_line;
    logic [COLUMN_BITS-1:0] error_column;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_BYTE      = 2'd0,
    ST_SLASH_ERR = 2'd1,
    ST_OPEN_ERR  = 2'd2,
    ST_CLEAN     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_SLASH     = 3'd1,
    MODE_LINE      = 3'd2,
    MODE_BLOCK     = 3'd3,
    MODE_STAR      = 3'd4,
    MODE_ERR_SLASH = 3'd5,
    MODE_ERR_OPEN  = 3'd6
  } scan_mode_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_SYMBOL = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_kind_t;

  // One queue entry expands into one to three output transactions.
  typedef struct packed {
    cmd_kind_t              kind;
    logic                   lead_nl;
    logic [7:0]             data;
    status_t                status;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } cmd_t;

endpackage

// ----- rtl/css_front.sv -----
// Front end: accepts input transactions, runs the comment scanner and
// line/column tracking, and pushes one command per result-producing item.
// Depends on css_pkg.
module css_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  css_pkg::in_item_t in_item,
  input  logic             q_ready,
  output logic             push,
  output css_pkg::cmd_t    cmd
);
  import css_pkg::*;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  scan_mode_t             mode, mode_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic [COLUMN_BITS-1:0] col_cnt, col_cnt_next;
  logic [COLUMN_BITS-1:0] slash_col, slash_col_next;
  logic                   line_has, line_has_next;
  logic                   accept;
  logic                   produce;
  logic [7:0]             b;

  function automatic logic is_symbol(input logic [7:0] c);
    is_symbol = (c == 8'h7B) || (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D) ||
                (c == 8'h28) || (c == 8'h29) || (c == 8'h3B) || (c == 8'h2C);
  endfunction

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && produce;
  assign b        = in_item.in_byte;

  always_comb begin
    mode_next      = mode;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    slash_col_next = slash_col;
    line_has_next  = line_has;
    produce        = 1'b0;
    cmd.kind       = CMD_BYTE;
    cmd.lead_nl    = 1'b0;
    cmd.data       = b;
    cmd.status     = ST_BYTE;
    cmd.line       = '0;
    cmd.column     = '0;
    if (mode == MODE_ERR_SLASH || mode == MODE_ERR_OPEN) begin
      produce    = 1'b1;
      cmd.kind   = CMD_STATUS;
      cmd.status = (mode == MODE_ERR_SLASH) ? ST_SLASH_ERR : ST_OPEN_ERR;
      cmd.line   = line_cnt;
      cmd.column = slash_col;
    end else if (in_item.end_of_input) begin
      produce  = 1'b1;
      cmd.kind = CMD_STATUS;
      if (mode == MODE_SLASH) begin
        mode_next  = MODE_ERR_SLASH;
        cmd.status = ST_SLASH_ERR;
        cmd.line   = line_cnt;
        cmd.column = slash_col;
      end else begin
        cmd.lead_nl = line_has;
        if (mode == MODE_BLOCK || mode == MODE_STAR) begin
          mode_next      = MODE_ERR_OPEN;
          slash_col_next = col_cnt;
          cmd.status     = ST_OPEN_ERR;
          cmd.line       = line_cnt;
          cmd.column     = col_cnt;
        end else begin
          cmd.status     = ST_CLEAN;
          mode_next      = MODE_NORMAL;
          line_cnt_next  = LINE_BITS'(1);
          col_cnt_next   = '0;
          slash_col_next = '0;
          line_has_next  = 1'b0;
        end
      end
    end else if (mode == MODE_SLASH && b != CH_SLASH && b != CH_STAR) begin
      produce    = 1'b1;
      mode_next  = MODE_ERR_SLASH;
      cmd.kind   = CMD_STATUS;
      cmd.status = ST_SLASH_ERR;
      cmd.line   = line_cnt;
      cmd.column = slash_col;
    end else if (b == CH_NEWLINE) begin
      produce = 1'b1;
      if (mode == MODE_LINE) begin
        mode_next = MODE_NORMAL;
      end else if (mode == MODE_STAR) begin
        mode_next = MODE_BLOCK;
      end
      if (line_cnt != LINE_MAX) begin
        line_cnt_next = line_cnt + 1'b1;
      end
      col_cnt_next  = '0;
      line_has_next = 1'b0;
    end else begin
      line_has_next = 1'b1;
      case (mode)
        MODE_NORMAL: begin
          if (b == CH_SLASH) begin
            slash_col_next = col_cnt;
            mode_next      = MODE_SLASH;
          end else begin
            produce  = 1'b1;
            cmd.kind = is_symbol(b) ? CMD_SYMBOL : CMD_BYTE;
          end
        end
        MODE_SLASH: begin
          mode_next = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) begin
            mode_next = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (b == CH_SLASH) begin
            mode_next = MODE_NORMAL;
          end else if (b != CH_STAR) begin
            mode_next = MODE_BLOCK;
          end
        end
        default: begin
        end
      endcase
      if (col_cnt != COL_MAX) begin
        col_cnt_next = col_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      line_cnt  <= LINE_BITS'(1);
      col_cnt   <= '0;
      slash_col <= '0;
      line_has  <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      slash_col <= slash_col_next;
      line_has  <= line_has_next;
    end
  end

endmodule

// ----- rtl/css_fifo.sv -----
// Command queue between front and back end of the comment stripper.
// Register-based circular buffer; depends on css_pkg for the entry type.
module css_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  css_pkg::cmd_t wr_data,
  output logic          wr_ready,
  input  logic          pop,
  output logic          rd_valid,
  output css_pkg::cmd_t rd_data
);
  import css_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;
  assign rd_data  = mem[rd_ptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/css_back.sv -----
// Back end: takes commands from the queue into a working register and
// expands each into its output transactions. Depends on css_pkg.
module css_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  css_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output css_pkg::out_item_t out_item
);
  import css_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] beat;
  logic [1:0] last_beat;
  logic       is_last;
  logic       out_fire;
  logic       load;

  always_comb begin
    case (cur.kind)
      CMD_SYMBOL: last_beat = 2'd2;
      CMD_STATUS: last_beat = cur.lead_nl ? 2'd1 : 2'd0;
      default:    last_beat = 2'd0;
    endcase
  end

  assign is_last   = (beat == last_beat);
  assign out_valid = cur_valid;
  assign out_fire  = out_valid && out_ready;
  assign load      = q_valid && (!cur_valid || (out_fire && is_last));
  assign q_pop     = load;

  always_comb begin
    out_item.out_byte     = cur.data;
    out_item.byte_valid   = 1'b1;
    out_item.status       = ST_BYTE;
    out_item.last_of_run  = is_last;
    out_item.error_line   = '0;
    out_item.error_column = '0;
    case (cur.kind)
      CMD_SYMBOL: begin
        if (beat != 2'd1) begin
          out_item.out_byte = CH_SPACE;
        end
      end
      CMD_STATUS: begin
        if (cur.lead_nl && beat == 2'd0) begin
          out_item.out_byte = CH_NEWLINE;
        end else begin
          out_item.out_byte     = '0;
          out_item.byte_valid   = 1'b0;
          out_item.status       = cur.status;
          out_item.error_line   = cur.line;
          out_item.error_column = cur.column;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      beat      <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        cur_valid <= 1'b0;
        beat      <= '0;
      end else begin
        beat <= beat + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/comment_strip_symbol_pad.sv -----
// Top level of the comment stripper with symbol padding.
// Instantiates css_front, css_fifo and css_back; depends on css_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one text byte per
//   transaction, or an end-of-input marker. Output channel
//   (out_valid/out_ready/out_item) carries output bytes and status results;
//   last_of_run marks the final result caused by one input transaction.
//   An accepted item passes the command queue and the back end's working
//   register before its first result. Throughput: one input transaction per
//   cycle while the queue has room. A plain byte or newline yields one output
//   transaction, a padded symbol three, an end of input one or two; bytes in
//   comments, newlines apart, yield none. The rate is set by the back end,
//   which emits one output transaction per cycle while out_ready is high;
//   the command queue of QUEUE_DEPTH entries absorbs the bursts. When the
//   receiver stalls, the queue fills and in_ready drops once it is full;
//   nothing is lost. Reset (rst, synchronous) returns the scanner to normal
//   text at line one, column zero, clears any sticky error and empties the
//   queue. A clean end of input also returns the scanner to that state.
module comment_strip_symbol_pad #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  css_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output css_pkg::out_item_t out_item
);
  import css_pkg::*;

  logic push, q_ready, q_valid, q_pop;
  cmd_t wr_cmd, rd_cmd;

  css_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_ready  (q_ready),
    .push     (push),
    .cmd      (wr_cmd)
  );

  css_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (wr_cmd),
    .wr_ready (q_ready),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (rd_cmd)
  );

  css_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (rd_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- tb/sv/comment_strip_symbol_pad_test.sv -----
// Self-checking testbench for comment_strip_symbol_pad: random-gap driver, stalling
// receiver, a scan-mode predictor and an in-order compare of every output transaction.
// Depends on css_pkg and the comment_strip_symbol_pad RTL.
module comment_strip_symbol_pad_test;
  import css_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 160;
  localparam int LONG_LINE    = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  text_q[$];
  out_item_t expected_out[$];

  scan_mode_t             mode_m = MODE_NORMAL;
  logic [LINE_BITS-1:0]   line_m = LINE_BITS'(1);
  logic [COLUMN_BITS-1:0] col_m = '0;
  logic [COLUMN_BITS-1:0] slash_col_m = '0;
  logic                   has_bytes_m = 1'b0;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clean_ends = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  bit end_on_slash;

  comment_strip_symbol_pad u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_pad_symbol(logic [7:0] b);
    case (b)
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3B, 8'h2C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 7))
      0: return 8'h7B;
      1: return 8'h7D;
      2: return 8'h5B;
      3: return 8'h5D;
      4: return 8'h28;
      5: return 8'h29;
      6: return 8'h3B;
      default: return 8'h2C;
    endcase
  endfunction

  function automatic out_item_t text_result(logic [7:0] b, logic v, status_t s);
    out_item_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = v;
    r.status     = s;
    return r;
  endfunction

  function automatic out_item_t error_result();
    out_item_t r;
    r = '0;
    r.status       = (mode_m == MODE_ERR_SLASH) ? ST_SLASH_ERR : ST_OPEN_ERR;
    r.error_line   = line_m;
    r.error_column = slash_col_m;
    return r;
  endfunction

  task automatic strip_predict(in_item_t it);
    out_item_t              res[$];
    logic [7:0]             b;
    logic [COLUMN_BITS-1:0] end_col;
    b = it.in_byte;
    if (mode_m == MODE_ERR_SLASH || mode_m == MODE_ERR_OPEN) begin
      res.push_back(error_result());
    end else if (it.end_of_input) begin
      if (mode_m == MODE_SLASH) begin
        mode_m = MODE_ERR_SLASH;
        res.push_back(error_result());
      end else begin
        end_col = col_m;
        if (has_bytes_m) res.push_back(text_result(CH_NEWLINE, 1'b1, ST_BYTE));
        if (mode_m == MODE_BLOCK || mode_m == MODE_STAR) begin
          mode_m      = MODE_ERR_OPEN;
          slash_col_m = end_col;
          res.push_back(error_result());
        end else begin
          res.push_back(text_result(8'h00, 1'b0, ST_CLEAN));
          mode_m      = MODE_NORMAL;
          line_m      = LINE_BITS'(1);
          col_m       = '0;
          slash_col_m = '0;
          has_bytes_m = 1'b0;
        end
      end
    end else if (mode_m == MODE_SLASH && b != CH_SLASH && b != CH_STAR) begin
      mode_m = MODE_ERR_SLASH;
      res.push_back(error_result());
    end else if (b == CH_NEWLINE) begin
      res.push_back(text_result(CH_NEWLINE, 1'b1, ST_BYTE));
      if (mode_m == MODE_LINE) mode_m = MODE_NORMAL;
      else if (mode_m == MODE_STAR) mode_m = MODE_BLOCK;
      if (line_m != '1) line_m = line_m + 1'b1;
      col_m       = '0;
      has_bytes_m = 1'b0;
    end else begin
      has_bytes_m = 1'b1;
      case (mode_m)
        MODE_NORMAL: begin
          if (b == CH_SLASH) begin
            slash_col_m = col_m;
            mode_m      = MODE_SLASH;
          end else if (is_pad_symbol(b)) begin
            res.push_back(text_result(CH_SPACE, 1'b1, ST_BYTE));
            res.push_back(text_result(b, 1'b1, ST_BYTE));
            res.push_back(text_result(CH_SPACE, 1'b1, ST_BYTE));
          end else begin
            res.push_back(text_result(b, 1'b1, ST_BYTE));
          end
        end
        MODE_SLASH: mode_m = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
        MODE_BLOCK: if (b == CH_STAR) mode_m = MODE_STAR;
        MODE_STAR: begin
          if (b == CH_SLASH) mode_m = MODE_NORMAL;
          else if (b != CH_STAR) mode_m = MODE_BLOCK;
        end
        default: ;
      endcase
      if (col_m != '1) col_m = col_m + 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) expected_out.push_back(res[i]);
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic add_byte(logic [7:0] b);
    text_q.push_back(in_item_t'{in_byte: b, end_of_input: 1'b0});
  endtask

  task automatic add_eoi();
    text_q.push_back(in_item_t'{in_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SLASH);
    return b;
  endfunction

  task automatic add_text();
    int         ntok;
    int         n;
    logic [7:0] b;
    logic [7:0] prev;
    ntok = $urandom_range(0, 12);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_byte(plain_byte());
        3, 4: add_byte(pick_symbol());
        5: add_byte(CH_NEWLINE);
        6, 7: begin
          add_byte(CH_SLASH);
          add_byte(CH_SLASH);
          n = $urandom_range(0, 6);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NEWLINE) b = CH_SLASH;
            add_byte(b);
          end
          if (t != ntok - 1 || $urandom_range(0, 1)) add_byte(CH_NEWLINE);
        end
        default: begin
          add_byte(CH_SLASH);
          add_byte(CH_STAR);
          prev = 8'h00;
          n = $urandom_range(0, 8);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0, 1: b = CH_STAR;
              2: b = CH_SLASH;
              3: b = CH_NEWLINE;
              default: b = 8'($urandom_range(0, 255));
            endcase
            if (b == CH_SLASH && prev == CH_STAR) b = CH_NEWLINE;
            add_byte(b);
            prev = b;
          end
          add_byte(CH_STAR);
          add_byte(CH_SLASH);
        end
      endcase
    end
    add_eoi();
  endtask

  task automatic add_error_tail();
    logic [7:0] b;
    add_byte(CH_SLASH);
    add_byte(CH_STAR);
    repeat (LONG_LINE) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_STAR || b == CH_NEWLINE) b = 8'h78;
      add_byte(b);
    end
    if (end_on_slash) begin
      add_byte(CH_STAR);
      add_byte(CH_SLASH);
      add_byte(CH_SLASH);
      case ($urandom_range(0, 2))
        0: begin
          do b = plain_byte(); while (b == CH_STAR);
          add_byte(b);
        end
        1: add_byte(CH_NEWLINE);
        default: add_eoi();
      endcase
    end else begin
      add_eoi();
    end
    repeat (6) begin
      if ($urandom_range(0, 2) == 0) add_eoi();
      else add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        strip_predict(in_item);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (text_q.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= text_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_tick++;
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_tick % 7 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected transaction %p", out_item));
      end else begin
        want = expected_out.pop_front();
        check_field("out_byte", 32'(out_item.out_byte), 32'(want.out_byte));
        check_field("byte_valid", 32'(out_item.byte_valid), 32'(want.byte_valid));
        check_field("status", 32'(out_item.status), 32'(want.status));
        check_field("last_of_run", 32'(out_item.last_of_run), 32'(want.last_of_run));
        check_field("error_line", 32'(out_item.error_line), 32'(want.error_line));
        check_field("error_column", 32'(out_item.error_column),
                    32'(want.error_column));
        if (want.status == ST_CLEAN) clean_ends++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[comment_strip_symbol_pad] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // empty text
    add_eoi();
    // all padded symbols, byte extremes, plain newline
    add_byte(8'h7B); add_byte(8'h7D); add_byte(8'h5B); add_byte(8'h5D);
    add_byte(8'h28); add_byte(8'h29); add_byte(8'h3B); add_byte(8'h2C);
    add_byte(8'h00); add_byte(8'hFF); add_byte(CH_NEWLINE);
    // slash-star-slash and a star-slash split by newline leave the comment open; the last star-slash closes it
    add_byte(CH_SLASH); add_byte(CH_STAR); add_byte(CH_SLASH); add_byte(CH_STAR);
    add_byte(CH_NEWLINE); add_byte(CH_SLASH); add_byte(CH_STAR); add_byte(CH_SLASH);
    add_eoi();
    // line comment cut by end of input
    add_byte(CH_SLASH); add_byte(CH_SLASH); add_byte(8'h71);
    add_eoi();
    while (text_q.size() < RANDOM_ITEMS - 40) add_text();
    end_on_slash = 1'($urandom_range(0, 1));
    add_error_tail();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (text_q.size() != 0 || in_valid);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input and %0d output transactions, %0d clean texts", items_sent,
             results_seen, clean_ends);
    $display("run ended on a sticky %s error",
             end_on_slash ? "stray slash" : "unterminated comment");
    if (mismatches == 0) begin
      $display("[comment_strip_symbol_pad] OK");
    end else begin
      $display("[comment_strip_symbol_pad] ERROR");
    end
    $finish;
  end

endmodule
